/* sv/enss_pkg.sv */
package enss_pkg;

    // Folded character held in one window cell
    typedef logic [7:0] char_t;

    // Control that every cell of the window sees
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // One verdict at the end of a list
    typedef struct packed {
        logic suspicious;
        logic name_reported;
    } verdict_t;

    localparam int unsigned PATTERN_COUNT = 8;
    localparam int unsigned ALLOW_COUNT   = 5;
    localparam int unsigned PAT_MAX       = 8;

    // Length of the threat name that goes into the report buffer
    localparam logic [15:0] THREAT_NAME_LEN = 16'd19;
    localparam logic [15:0] BUF_SIZE_RESET  = 16'd256;

    // Allow patterns first, then deny patterns
    localparam int unsigned PAT_LEN [PATTERN_COUNT] = '{2, 4, 8, 5, 2, 4, 5, 6};

    localparam char_t PAT_CHARS [PATTERN_COUNT][PAT_MAX] = '{
        '{"p", "y", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "c", "a", "n", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "h", "r", "o", "m", "i", "u", "m"},
        '{"b", "l", "i", "n", "k", 8'h00, 8'h00, 8'h00},
        '{"q", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"h", "o", "o", "k", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"v", "i", "r", "u", "s", 8'h00, 8'h00, 8'h00},
        '{"b", "y", "p", "a", "s", "s", 8'h00, 8'h00}
    };

endpackage

/* sv/export_name_signature_scan.sv */
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   code_unit, has_char, last_of_name, last_of_list
// result    out        out_valid / out_ready suspicious, name_reported
// config    in         cfg_valid / cfg_ready cfg_data (report buffer size)
//
// One code unit is taken every cycle while the result queue has room; the window of cells
// shifts and is matched in the same cycle the unit is accepted.
// A verdict is written into the result queue when the list-ending unit is accepted.
// A two-entry result queue sets the stall point: input stalls only when it is full.
// Reset clears the window, the name and list flags, the queue, and sets the
// buffer size to 256. Config is always ready.
module export_name_signature_scan
    import enss_pkg::*;
#(
    parameter int unsigned WINDOW_LEN = 8,
    parameter int unsigned UNIT_BITS  = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [UNIT_BITS-1:0] code_unit,
    input  logic                 has_char,
    input  logic                 last_of_name,
    input  logic                 last_of_list,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 suspicious,
    output logic                 name_reported,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data
);

    logic        in_fire;
    logic        out_fire;
    logic        push_char;
    logic        end_name;
    char_t       folded;
    char_t       win [WINDOW_LEN];
    char_t       nb_in [WINDOW_LEN];
    cell_ctrl_t  cell_ctrl;
    logic        allow_hit;
    logic        deny_hit;
    logic        allow_now;
    logic        deny_now;
    logic        detect_now;
    verdict_t    verdict;

    logic [15:0] buf_size_reg;
    logic        name_allowed_reg;
    logic        name_allowed_next;
    logic        name_denied_reg;
    logic        name_denied_next;
    logic        list_detected_reg;
    logic        list_detected_next;

    verdict_t    q_reg [2];
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        rd_ptr_reg;
    logic        wr_ptr_reg;
    logic        q_push;

    assign in_ready  = (count_reg != 2'd2);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (count_reg != 2'd0);
    assign out_fire  = out_valid && out_ready;
    assign cfg_ready = 1'b1;

    // Fold ASCII upper case to lower case; drop anything outside ASCII
    always_comb
    begin
        folded = {1'b0, code_unit[6:0]};
        if (code_unit[UNIT_BITS-1:7] != '0)
        begin
            folded = '0;
        end
        else if (folded >= "A" && folded <= "Z")
        begin
            folded = folded + 8'd32;
        end
    end

    assign push_char       = in_fire && has_char;
    assign end_name        = in_fire && (last_of_name || last_of_list);
    assign cell_ctrl.shift = push_char;
    assign cell_ctrl.clear = end_name;

    // Chain of window cells: oldest at index 0, newest at the top
    for (genvar j = 0; j < WINDOW_LEN; j++)
    begin : g_cell
        if (j == WINDOW_LEN - 1)
        begin : g_top
            assign nb_in[j] = folded;
        end
        else
        begin : g_mid
            assign nb_in[j] = win[j+1];
        end

        enss_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (cell_ctrl),
            .ch_in  (nb_in[j]),
            .ch_out (win[j])
        );
    end

    enss_match #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_match (
        .win       (win),
        .ch_new    (folded),
        .allow_hit (allow_hit),
        .deny_hit  (deny_hit)
    );

    // Update name and list flags
    always_comb
    begin
        allow_now  = name_allowed_reg || (push_char && allow_hit);
        deny_now   = name_denied_reg || (push_char && deny_hit);
        detect_now = list_detected_reg || (deny_now && !allow_now);

        name_allowed_next  = allow_now;
        name_denied_next   = deny_now;
        list_detected_next = list_detected_reg;
        if (end_name)
        begin
            name_allowed_next  = 1'b0;
            name_denied_next   = 1'b0;
            list_detected_next = detect_now;
        end
        if (in_fire && last_of_list)
        begin
            list_detected_next = 1'b0;
        end

        verdict.suspicious    = detect_now && (buf_size_reg != 16'd0);
        verdict.name_reported = verdict.suspicious && (buf_size_reg > THREAT_NAME_LEN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_allowed_reg  <= 1'b0;
            name_denied_reg   <= 1'b0;
            list_detected_reg <= 1'b0;
            buf_size_reg      <= BUF_SIZE_RESET;
        end
        else
        begin
            name_allowed_reg  <= name_allowed_next;
            name_denied_reg   <= name_denied_next;
            list_detected_reg <= list_detected_next;
            if (cfg_valid && cfg_ready)
            begin
                buf_size_reg <= cfg_data;
            end
        end
    end

    // Result queue: push on a list end, pop on an output transaction
    assign q_push = in_fire && last_of_list;

    always_comb
    begin
        count_next = count_reg;
        case ({q_push, out_fire})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (q_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (out_fire)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_reg[wr_ptr_reg] <= verdict;
        end
    end

    assign suspicious    = q_reg[rd_ptr_reg].suspicious;
    assign name_reported = q_reg[rd_ptr_reg].name_reported;

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result queue count out of range");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !out_fire) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("result queue did not grow on push");

    a_name_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        end_name |=> (!name_allowed_reg && !name_denied_reg && win[WINDOW_LEN-1] == 8'd0))
        else $error("name state not cleared at end of name");

    a_report_implies_susp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!name_reported || suspicious))
        else $error("name reported without suspicious verdict");

endmodule

/* sv/enss_cell.sv */
module enss_cell
    import enss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  char_t      ch_in,
    output char_t      ch_out
);

    char_t ch_reg;
    char_t ch_next;

    // Clear at end of name, otherwise take the neighbor's character on a shift
    always_comb
    begin
        ch_next = ch_reg;
        if (ctrl.clear)
        begin
            ch_next = '0;
        end
        else if (ctrl.shift)
        begin
            ch_next = ch_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg <= '0;
        end
        else
        begin
            ch_reg <= ch_next;
        end
    end

    assign ch_out = ch_reg;

endmodule

/* sv/enss_match.sv */
module enss_match
    import enss_pkg::*;
#(
    parameter int unsigned WINDOW_LEN = 8
)
(
    input  char_t win [WINDOW_LEN],
    input  char_t ch_new,
    output logic  allow_hit,
    output logic  deny_hit
);

    logic [PATTERN_COUNT-1:0] hit;

    // Compare the window as it stands after the shift: newest character
    // plus the older cells, counted back from the newest end
    always_comb
    begin
        for (int k = 0; k < PATTERN_COUNT; k++)
        begin
            hit[k] = (ch_new == PAT_CHARS[k][PAT_LEN[k]-1]);
            for (int j = 0; j < PAT_MAX - 1; j++)
            begin
                if (j <= int'(PAT_LEN[k]) - 2)
                begin
                    hit[k] = hit[k] &&
                             (win[WINDOW_LEN-1-j] == PAT_CHARS[k][PAT_LEN[k]-2-j]);
                end
            end
        end
    end

    assign allow_hit = |hit[ALLOW_COUNT-1:0];
    assign deny_hit  = |hit[PATTERN_COUNT-1:ALLOW_COUNT];

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    import enss_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          IDLE_PCT    = 18;
    localparam int          LONG_HOLD   = 300;
    localparam int          PHASE_UNITS = 265;
    localparam logic [15:0] THREAT_LEN  = 16'd19;

    typedef struct {
        logic [15:0] code_unit;
        logic        has_char;
        logic        last_of_name;
        logic        last_of_list;
    } scan_unit_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [15:0] code_unit     = '0;
    logic        has_char      = 1'b0;
    logic        last_of_name  = 1'b0;
    logic        last_of_list  = 1'b0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic        suspicious;
    logic        name_reported;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data      = '0;

    // Pending code units and the verdicts they are due to produce
    scan_unit_t  unit_q[$];
    verdict_t    verdict_q[$];
    scan_unit_t  cur_unit;
    verdict_t    want;
    int          units_made  = 0;
    int          units_taken = 0;
    int          errors      = 0;
    int          cycles      = 0;

    // Shadow of the scanner: window of folded chars (newest in the low byte)
    logic [63:0] tail_chars  = '0;
    logic        name_allow  = 1'b0;
    logic        name_deny   = 1'b0;
    logic        list_hit    = 1'b0;
    logic [15:0] buf_size    = BUF_SIZE_RESET;

    // Traffic shaping knobs owned by the sequence block
    logic        calm        = 1'b0;
    logic        squeeze     = 1'b0;
    logic        squeeze_done = 1'b0;
    int          hold_left   = 0;

    string allow_words[5] = '{"py", "scan", "chromium", "blink", "qt"};
    string deny_words[3]  = '{"hook", "virus", "bypass"};

    export_name_signature_scan dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .code_unit     (code_unit),
        .has_char      (has_char),
        .last_of_name  (last_of_name),
        .last_of_list  (last_of_list),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .suspicious    (suspicious),
        .name_reported (name_reported),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Fold ASCII letters to lower case; anything outside 7-bit ASCII becomes zero
    function automatic logic [7:0] fold_char(input logic [15:0] u);
        if (u >= 16'h0080)
            return 8'h00;
        if (u >= "A" && u <= "Z")
            return u[7:0] + 8'd32;
        return u[7:0];
    endfunction

    // Advance the shadow scanner by one accepted code unit
    task automatic judge_unit(input scan_unit_t u);
        verdict_t v;
        if (u.has_char)
        begin
            tail_chars = {tail_chars[55:0], fold_char(u.code_unit)};
            if (tail_chars[15:0] == "py" || tail_chars[31:0] == "scan" ||
                tail_chars == "chromium" || tail_chars[39:0] == "blink" ||
                tail_chars[15:0] == "qt")
                name_allow = 1'b1;
            if (tail_chars[31:0] == "hook" || tail_chars[39:0] == "virus" ||
                tail_chars[47:0] == "bypass")
                name_deny = 1'b1;
        end
        if (u.last_of_name || u.last_of_list)
        begin
            if (name_deny && !name_allow)
                list_hit = 1'b1;
            tail_chars = '0;
            name_allow = 1'b0;
            name_deny  = 1'b0;
        end
        if (u.last_of_list)
        begin
            v.suspicious    = list_hit && (buf_size != 16'd0);
            v.name_reported = v.suspicious && (buf_size > THREAT_LEN);
            verdict_q.push_back(v);
            list_hit = 1'b0;
        end
    endtask

    task automatic add_unit(input logic [15:0] cu, input logic hc, input logic lon,
                            input logic lol);
        scan_unit_t u;
        u.code_unit    = cu;
        u.has_char     = hc;
        u.last_of_name = lon;
        u.last_of_list = lol;
        unit_q.push_back(u);
        units_made++;
    endtask

    // Queue a word as characters, optionally with random upper case letters
    task automatic add_word(input string w, input bit mixcase);
        logic [7:0] ch;
        for (int i = 0; i < w.len(); i++)
        begin
            ch = w[i];
            if (mixcase && ch >= "a" && ch <= "z" && $urandom_range(0, 1))
                ch = ch - 8'd32;
            add_unit({8'h00, ch}, 1'b1, 1'b0, 1'b0);
        end
    endtask

    task automatic add_noise(input int count);
        repeat (count)
            add_unit(16'($urandom), 1'($urandom), 1'($urandom), $urandom_range(0, 7) == 0);
    endtask

    // Queue one list of names built from pattern words and filler characters
    task automatic add_list(input int max_names, input int max_frags);
        int         names;
        int         frags;
        int         pick;
        int         start;
        logic [7:0] ch;
        names = $urandom_range(0, max_names);
        start = units_made;
        for (int n = 0; n < names; n++)
        begin
            start = units_made;
            frags = $urandom_range(0, max_frags);
            for (int f = 0; f < frags; f++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    add_word(deny_words[$urandom_range(0, 2)], 1'b1);
                else if (pick < 5)
                    add_word(allow_words[$urandom_range(0, 4)], 1'b1);
                else if (pick < 8)
                begin
                    ch = "a";
                    ch = ch + 8'($urandom_range(0, 25));
                    if ($urandom_range(0, 1))
                        ch = ch - 8'd32;
                    add_unit({8'h00, ch}, 1'b1, 1'b0, 1'b0);
                end
                else if (pick == 8)
                    add_unit(16'($urandom), 1'b1, 1'b0, 1'b0);
                else
                    add_unit(16'($urandom_range(0, 127)), 1'b1, 1'b0, 1'b0);
            end
            // close all but the last name, on its last char or with a marker
            if (n < names - 1)
            begin
                if (units_made > start && $urandom_range(0, 1))
                    unit_q[$].last_of_name = 1'b1;
                else
                    add_unit(16'($urandom), 1'b0, 1'b1, 1'b0);
            end
        end
        pick = $urandom_range(0, 2);
        if (names > 0 && units_made > start && pick == 0)
        begin
            unit_q[$].last_of_list = 1'b1;
            unit_q[$].last_of_name = 1'($urandom);
        end
        else
            add_unit(16'($urandom), 1'b0, 1'($urandom), 1'b1);
    endtask

    // Hold until every unit is taken and every verdict has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (units_taken != units_made || in_valid || verdict_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_buf_size(input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        buf_size = val;
        cfg_valid <= 1'b0;
    endtask

    // Input driver: predict on each accepted transaction, then offer the next unit
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                judge_unit(cur_unit);
                units_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (unit_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    cur_unit = unit_q.pop_front();
                    in_valid     <= 1'b1;
                    code_unit    <= cur_unit.code_unit;
                    has_char     <= cur_unit.has_char;
                    last_of_name <= cur_unit.last_of_name;
                    last_of_list <= cur_unit.last_of_list;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each verdict transaction, then pick the next ready
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("unexpected verdict: suspicious=%0b name_reported=%0b",
                           suspicious, name_reported);
                    errors++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (suspicious !== want.suspicious)
                    begin
                        $error("suspicious: expected %0b, got %0b", want.suspicious, suspicious);
                        errors++;
                    end
                    if (name_reported !== want.name_reported)
                    begin
                        $error("name_reported: expected %0b, got %0b",
                               want.name_reported, name_reported);
                        errors++;
                    end
                end
            end
            // hold off once for a long stretch so the result queue fills up
            if (squeeze && !squeeze_done)
            begin
                squeeze_done <= 1'b1;
                hold_left    <= LONG_HOLD;
                out_ready    <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] sizes [7];
        int          target;
        sizes    = '{16'd0, 16'd19, 16'd20, 16'hFFFF, 16'd1, 16'd0, 16'd256};
        sizes[5] = 16'($urandom);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed lists under the reset buffer size
        add_word("PyHooK", 1'b0);
        unit_q[$].last_of_name = 1'b1;
        add_word("vIRUS", 1'b0);
        add_unit(16'hFFFF, 1'b0, 1'b0, 1'b1);
        add_unit(16'h0000, 1'b0, 1'b0, 1'b1);
        add_word("hoo", 1'b0);
        add_unit(16'h016B, 1'b1, 1'b1, 1'b0);
        add_unit(16'h0000, 1'b1, 1'b0, 1'b0);
        add_unit(16'h007F, 1'b1, 1'b0, 1'b0);
        add_unit(16'hFFFF, 1'b1, 1'b0, 1'b1);
        add_word("BYPASS", 1'b0);
        unit_q[$].last_of_name = 1'b1;
        unit_q[$].last_of_list = 1'b1;
        wait_drained();

        // Random lists, one buffer size per phase
        for (int p = 0; p < 7; p++)
        begin
            write_buf_size(sizes[p]);
            @(negedge clk);
            squeeze <= (p == 3);
            calm    <= (p == 4);
            target = units_made + PHASE_UNITS;
            while (units_made < target)
            begin
                if ($urandom_range(0, 9) == 0)
                    add_noise($urandom_range(1, 6));
                if (p == 3)
                    add_list(1, 2);
                else
                    add_list(4, 4);
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (errors == 0 && verdict_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
